// ===== design/mcac_pkg.sv =====
// shared types, constants and tables for the multichannel audio compressor
// used by every module of the block; no dependencies

package mcac_pkg;

  localparam int LANES = 6;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W = 33;
  localparam int MEAN_W = 31;
  localparam int LOG_W = 21;
  localparam int T_W = 22;
  localparam int ACC_W = 31;
  localparam int C_W = 30;
  localparam int CNT_W = 5;

  localparam logic [15:0] UNITY_Q15 = 16'h8000;
  localparam logic [CNT_W-1:0] ITER_LAST = 5'd15;
  localparam logic [CNT_W-1:0] LANE_LAST = 5'(LANES - 1);

  // register indexes on the configuration port
  localparam logic [2:0] REG_EFFECT_ENABLED = 3'd0;
  localparam logic [2:0] REG_ACTIVE_CHANNELS = 3'd1;
  localparam logic [2:0] REG_THRESHOLD_LEVEL = 3'd2;
  localparam logic [2:0] REG_RATIO_Q8 = 3'd3;
  localparam logic [2:0] REG_MAKEUP_GAIN_Q12 = 3'd4;
  localparam logic [2:0] REG_STATS_ENABLE = 3'd5;
  localparam logic [2:0] REG_STATS_CLEAR_ON_START = 3'd6;

  typedef struct packed {
    logic        effect_enabled;
    logic [3:0]  active_channels;
    logic [30:0] threshold_level;
    logic [15:0] ratio_q8;
    logic [15:0] makeup_gain_q12;
    logic        stats_enable;
    logic        stats_clear_on_start;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic signed [15:0] sample_c;
    logic signed [15:0] sample_d;
    logic signed [15:0] sample_e;
    logic signed [15:0] sample_f;
    logic               buffer_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_a;
    logic signed [15:0] out_b;
    logic signed [15:0] out_c;
    logic signed [15:0] out_d;
    logic signed [15:0] out_e;
    logic signed [15:0] out_f;
    logic [15:0]        frame_gain;
    logic [30:0]        peak_mean;
    logic [15:0]        lowest_gain;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PASS,
    OP_SQ,
    OP_DIVM_GO,
    OP_DIVM_SAVE,
    OP_DIVE_GO,
    OP_DIVE_SAVE,
    OP_GAIN_UNITY,
    OP_GAIN_ZERO,
    OP_LOG_LD_M,
    OP_LOG_LD_T,
    OP_LOG_NORM,
    OP_LOG_SQ,
    OP_MULT,
    OP_EXP,
    OP_EXP_FIN,
    OP_GMUL,
    OP_SCALE,
    OP_STATS
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] idx;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic last_lane;
    logic div_done;
    logic above;
    logic thr_zero;
    logic e_zero;
    logic m_norm;
  } dp_status_t;

  typedef logic [16:1][C_W-1:0] exp_tab_t;

  // truncated integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] bit_v;
    r = '0;
    rem = v;
    bit_v = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // factors 2^(-2^-i) in Q0.30, each the root of the one before
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] c;
    c = 64'h2000_0000;
    for (int i = 1; i <= 16; i++) begin
      c = isqrt64(c << 30);
      tab[i] = c[C_W-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== design/mcac_regs.sv =====
// configuration register file behind the apb-style port
// depends on mcac_pkg for the register indexes and cfg_t

module mcac_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mcac_pkg::cfg_t    cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_enabled <= 1'b0;
      cfg.active_channels <= 4'd2;
      cfg.threshold_level <= 31'h4000_0000;
      cfg.ratio_q8 <= 16'd256;
      cfg.makeup_gain_q12 <= 16'd4096;
      cfg.stats_enable <= 1'b0;
      cfg.stats_clear_on_start <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        mcac_pkg::REG_EFFECT_ENABLED: cfg.effect_enabled <= pwdata[0];
        mcac_pkg::REG_ACTIVE_CHANNELS: cfg.active_channels <= pwdata[3:0];
        mcac_pkg::REG_THRESHOLD_LEVEL: cfg.threshold_level <= pwdata[30:0];
        mcac_pkg::REG_RATIO_Q8: cfg.ratio_q8 <= pwdata[15:0];
        mcac_pkg::REG_MAKEUP_GAIN_Q12: cfg.makeup_gain_q12 <= pwdata[15:0];
        mcac_pkg::REG_STATS_ENABLE: cfg.stats_enable <= pwdata[0];
        mcac_pkg::REG_STATS_CLEAR_ON_START: cfg.stats_clear_on_start <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      mcac_pkg::REG_EFFECT_ENABLED: prdata = 32'(cfg.effect_enabled);
      mcac_pkg::REG_ACTIVE_CHANNELS: prdata = 32'(cfg.active_channels);
      mcac_pkg::REG_THRESHOLD_LEVEL: prdata = 32'(cfg.threshold_level);
      mcac_pkg::REG_RATIO_Q8: prdata = 32'(cfg.ratio_q8);
      mcac_pkg::REG_MAKEUP_GAIN_Q12: prdata = 32'(cfg.makeup_gain_q12);
      mcac_pkg::REG_STATS_ENABLE: prdata = 32'(cfg.stats_enable);
      mcac_pkg::REG_STATS_CLEAR_ON_START: prdata = 32'(cfg.stats_clear_on_start);
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/mcac_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on mcac_pkg for widths

module mcac_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mcac_pkg::SUM_W-1:0]    dividend,
  input  logic [15:0]                   divisor,
  output logic [mcac_pkg::SUM_W-1:0]    quotient,
  output logic                          done
);

  logic                         busy;
  logic [5:0]                   cnt;
  logic [mcac_pkg::SUM_W-1:0]   dvd;
  logic [15:0]                  rem;
  logic [15:0]                  dsr;
  logic [16:0]                  rs;
  logic                         qbit;

  // trial subtract of the shifted remainder
  assign rs = {rem, dvd[mcac_pkg::SUM_W-1]};
  assign qbit = rs >= {1'b0, dsr};
  assign quotient = dvd;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(mcac_pkg::SUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient shifts in as the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= qbit ? 16'(rs - {1'b0, dsr}) : rs[15:0];
      dvd <= {dvd[mcac_pkg::SUM_W-2:0], qbit};
    end
  end

endmodule

// ===== design/mcac_dp.sv =====
// datapath: sample store, sum of squares, log2/exp2 gain, lane scaling, statistics
// depends on mcac_pkg and mcac_div

module mcac_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  mcac_pkg::cfg_t          cfg,
  input  mcac_pkg::in_item_t      in_data,
  input  mcac_pkg::dp_cmd_t       cmd,
  output mcac_pkg::dp_status_t    status,
  output mcac_pkg::out_item_t     out_data
);

  logic signed [15:0]                 smp [mcac_pkg::LANES];
  logic signed [15:0]                 res [mcac_pkg::LANES];
  logic                               bstart;
  logic [mcac_pkg::SUM_W-1:0]         sum;
  logic [mcac_pkg::MEAN_W-1:0]        mean;
  logic [16:0]                        e;
  logic [30:0]                        m;
  logic [4:0]                         p;
  logic [15:0]                        frac;
  logic [mcac_pkg::LOG_W-1:0]         lmean;
  logic [mcac_pkg::T_W-1:0]           t;
  logic [mcac_pkg::ACC_W-1:0]         acc;
  logic [15:0]                        gain;
  logic [31:0]                        gm;
  logic [30:0]                        peak;
  logic [15:0]                        low;

  logic [3:0]                         n;
  logic [15:0]                        ratio;
  logic [2:0]                         lane;
  logic signed [15:0]                 cur;
  logic [15:0]                        cur_abs;
  logic [31:0]                        sq;
  logic [61:0]                        msq;
  logic [31:0]                        msh;
  logic [mcac_pkg::LOG_W-1:0]         dd;
  logic [37:0]                        tprod;
  logic [60:0]                        aprod;
  logic [5:0]                         k;
  logic [mcac_pkg::ACC_W-1:0]         gshift;
  logic [47:0]                        sprod;
  logic [48:0]                        srnd;
  logic [21:0]                        r;
  logic [15:0]                        mag;
  logic                               div_start;
  logic [mcac_pkg::SUM_W-1:0]         div_dvd;
  logic [15:0]                        div_dsr;
  logic [mcac_pkg::SUM_W-1:0]         div_q;
  logic                               div_done;
  logic [30:0]                        pk;
  logic [15:0]                        lw;

  assign n = cfg.active_channels;
  assign ratio = (cfg.ratio_q8 < 16'd256) ? 16'd256 : cfg.ratio_q8;

  // status back to the controller
  assign status.bypass = !cfg.effect_enabled || n == 4'd0 || n > 4'(mcac_pkg::LANES);
  assign status.last_lane = cmd.idx[3:0] == n - 4'd1;
  assign status.div_done = div_done;
  assign status.above = mean > cfg.threshold_level;
  assign status.thr_zero = cfg.threshold_level == 31'd0;
  assign status.e_zero = e == 17'd0;
  assign status.m_norm = m[30];

  // divider operand select
  assign div_start = cmd.op == mcac_pkg::OP_DIVM_GO || cmd.op == mcac_pkg::OP_DIVE_GO;
  assign div_dvd = (cmd.op == mcac_pkg::OP_DIVM_GO) ? sum : 33'h100_0000;
  assign div_dsr = (cmd.op == mcac_pkg::OP_DIVM_GO) ? 16'(n) : ratio;

  mcac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .done     (div_done)
  );

  // current lane magnitude and square
  assign lane = cmd.idx[2:0];
  assign cur = smp[lane];
  assign cur_abs = cur[15] ? (~cur + 16'd1) : cur;
  assign sq = cur_abs * cur_abs;

  // log2 mantissa squaring
  assign msq = m * m;
  assign msh = msq[61:30];

  // exponent product from the log difference
  assign dd = lmean - {p, frac};
  assign tprod = dd * e;

  // exp2 factor product
  assign aprod = acc * mcac_pkg::EXP_TAB[5'(cmd.idx[3:0]) + 5'd1];
  assign k = t[21:16];
  assign gshift = acc >> (7'(k) + 7'd15);

  // lane scaling with rounding and saturation
  assign sprod = cur_abs * gm;
  assign srnd = {1'b0, sprod} + 49'h400_0000;
  assign r = srnd[48:27];
  always_comb begin
    if (cur[15]) begin
      mag = (r > 22'd32768) ? 16'h8000 : r[15:0];
    end else begin
      mag = (r > 22'd32767) ? 16'h7fff : r[15:0];
    end
  end

  // statistics after an optional clear
  always_comb begin
    pk = (bstart && cfg.stats_clear_on_start) ? 31'd0 : peak;
    lw = (bstart && cfg.stats_clear_on_start) ? mcac_pkg::UNITY_Q15 : low;
    if (cfg.stats_enable) begin
      if (mean > pk) begin
        pk = mean;
      end
      if (gain < lw) begin
        lw = gain;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      mcac_pkg::OP_LOAD: begin
        smp[0] <= in_data.sample_a;
        smp[1] <= in_data.sample_b;
        smp[2] <= in_data.sample_c;
        smp[3] <= in_data.sample_d;
        smp[4] <= in_data.sample_e;
        smp[5] <= in_data.sample_f;
        bstart <= in_data.buffer_start;
        sum <= '0;
      end
      mcac_pkg::OP_PASS: begin
        for (int i = 0; i < mcac_pkg::LANES; i++) begin
          res[i] <= smp[i];
        end
        gain <= mcac_pkg::UNITY_Q15;
      end
      mcac_pkg::OP_SQ: sum <= sum + 33'(sq);
      mcac_pkg::OP_DIVM_SAVE: mean <= div_q[mcac_pkg::MEAN_W-1:0];
      mcac_pkg::OP_DIVE_SAVE: e <= 17'h10000 - div_q[16:0];
      mcac_pkg::OP_GAIN_UNITY: gain <= mcac_pkg::UNITY_Q15;
      mcac_pkg::OP_GAIN_ZERO: gain <= 16'd0;
      mcac_pkg::OP_LOG_LD_M: begin
        m <= mean;
        p <= 5'd30;
        frac <= '0;
      end
      mcac_pkg::OP_LOG_LD_T: begin
        lmean <= {p, frac};
        m <= cfg.threshold_level;
        p <= 5'd30;
        frac <= '0;
      end
      mcac_pkg::OP_LOG_NORM: begin
        m <= {m[29:0], 1'b0};
        p <= p - 5'd1;
      end
      mcac_pkg::OP_LOG_SQ: begin
        frac <= {frac[14:0], msh[31]};
        m <= msh[31] ? msh[31:1] : msh[30:0];
      end
      mcac_pkg::OP_MULT: begin
        t <= tprod[37:16];
        acc <= 31'h4000_0000;
      end
      mcac_pkg::OP_EXP: begin
        if (t[4'd15 - cmd.idx[3:0]]) begin
          acc <= aprod[60:30];
        end
      end
      mcac_pkg::OP_EXP_FIN: gain <= (k >= 6'd31) ? 16'd0 : gshift[15:0];
      mcac_pkg::OP_GMUL: gm <= gain * cfg.makeup_gain_q12;
      mcac_pkg::OP_SCALE: begin
        if (cmd.idx[3:0] < n) begin
          res[lane] <= cur[15] ? (~mag + 16'd1) : mag;
        end else begin
          res[lane] <= '0;
        end
      end
      default: ;
    endcase
  end

  // statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
      low <= mcac_pkg::UNITY_Q15;
    end else if (cmd.op == mcac_pkg::OP_STATS) begin
      peak <= pk;
      low <= lw;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.out_a <= res[0];
      out_data.out_b <= res[1];
      out_data.out_c <= res[2];
      out_data.out_d <= res[3];
      out_data.out_e <= res[4];
      out_data.out_f <= res[5];
      out_data.frame_gain <= gain;
      out_data.peak_mean <= peak;
      out_data.lowest_gain <= low;
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> gain <= mcac_pkg::UNITY_Q15)
    else $error("frame gain above unity");

  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op == mcac_pkg::OP_DIVM_SAVE) |-> mean <= 31'h4000_0000)
    else $error("mean square out of range");

endmodule

// ===== design/mcac_ctrl.sv =====
// sequencer for the compressor datapath and the channel handshakes
// depends on mcac_pkg for the command and status structs

module mcac_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  mcac_pkg::dp_status_t    status,
  output mcac_pkg::dp_cmd_t       cmd
);

  typedef enum logic [20:0] {
    S_IDLE      = 21'd1 << 0,
    S_PASS      = 21'd1 << 1,
    S_SQ        = 21'd1 << 2,
    S_DIVM_GO   = 21'd1 << 3,
    S_DIVM_WAIT = 21'd1 << 4,
    S_DIVE_GO   = 21'd1 << 5,
    S_DIVE_WAIT = 21'd1 << 6,
    S_CHK       = 21'd1 << 7,
    S_LOGM_LD   = 21'd1 << 8,
    S_LOGM_NORM = 21'd1 << 9,
    S_LOGM_SQ   = 21'd1 << 10,
    S_LOGT_LD   = 21'd1 << 11,
    S_LOGT_NORM = 21'd1 << 12,
    S_LOGT_SQ   = 21'd1 << 13,
    S_MULT      = 21'd1 << 14,
    S_EXP       = 21'd1 << 15,
    S_EXP_FIN   = 21'd1 << 16,
    S_GMUL      = 21'd1 << 17,
    S_SCALE     = 21'd1 << 18,
    S_STATS     = 21'd1 << 19,
    S_DONE      = 21'd1 << 20
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [mcac_pkg::CNT_W-1:0]   cnt;
  logic [mcac_pkg::CNT_W-1:0]   cnt_next;

  assign in_stall = state != S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd.op = mcac_pkg::OP_NONE;
    cmd.idx = cnt;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = mcac_pkg::OP_LOAD;
          cnt_next = '0;
          state_next = status.bypass ? S_PASS : S_SQ;
        end
      end
      S_PASS: begin
        cmd.op = mcac_pkg::OP_PASS;
        state_next = S_DONE;
      end
      S_SQ: begin
        cmd.op = mcac_pkg::OP_SQ;
        cnt_next = cnt + 5'd1;
        if (status.last_lane) begin
          state_next = S_DIVM_GO;
        end
      end
      S_DIVM_GO: begin
        cmd.op = mcac_pkg::OP_DIVM_GO;
        state_next = S_DIVM_WAIT;
      end
      S_DIVM_WAIT: begin
        if (status.div_done) begin
          cmd.op = mcac_pkg::OP_DIVM_SAVE;
          state_next = S_DIVE_GO;
        end
      end
      S_DIVE_GO: begin
        cmd.op = mcac_pkg::OP_DIVE_GO;
        state_next = S_DIVE_WAIT;
      end
      S_DIVE_WAIT: begin
        if (status.div_done) begin
          cmd.op = mcac_pkg::OP_DIVE_SAVE;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!status.above) begin
          cmd.op = mcac_pkg::OP_GAIN_UNITY;
          state_next = S_GMUL;
        end else if (status.thr_zero) begin
          cmd.op = status.e_zero ? mcac_pkg::OP_GAIN_UNITY : mcac_pkg::OP_GAIN_ZERO;
          state_next = S_GMUL;
        end else begin
          state_next = S_LOGM_LD;
        end
      end
      S_LOGM_LD: begin
        cmd.op = mcac_pkg::OP_LOG_LD_M;
        state_next = S_LOGM_NORM;
      end
      S_LOGM_NORM: begin
        cnt_next = '0;
        if (status.m_norm) begin
          state_next = S_LOGM_SQ;
        end else begin
          cmd.op = mcac_pkg::OP_LOG_NORM;
        end
      end
      S_LOGM_SQ: begin
        cmd.op = mcac_pkg::OP_LOG_SQ;
        cnt_next = cnt + 5'd1;
        if (cnt == mcac_pkg::ITER_LAST) begin
          state_next = S_LOGT_LD;
        end
      end
      S_LOGT_LD: begin
        cmd.op = mcac_pkg::OP_LOG_LD_T;
        state_next = S_LOGT_NORM;
      end
      S_LOGT_NORM: begin
        cnt_next = '0;
        if (status.m_norm) begin
          state_next = S_LOGT_SQ;
        end else begin
          cmd.op = mcac_pkg::OP_LOG_NORM;
        end
      end
      S_LOGT_SQ: begin
        cmd.op = mcac_pkg::OP_LOG_SQ;
        cnt_next = cnt + 5'd1;
        if (cnt == mcac_pkg::ITER_LAST) begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        cmd.op = mcac_pkg::OP_MULT;
        cnt_next = '0;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.op = mcac_pkg::OP_EXP;
        cnt_next = cnt + 5'd1;
        if (cnt == mcac_pkg::ITER_LAST) begin
          state_next = S_EXP_FIN;
        end
      end
      S_EXP_FIN: begin
        cmd.op = mcac_pkg::OP_EXP_FIN;
        state_next = S_GMUL;
      end
      S_GMUL: begin
        cmd.op = mcac_pkg::OP_GMUL;
        cnt_next = '0;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op = mcac_pkg::OP_SCALE;
        cnt_next = cnt + 5'd1;
        if (cnt == mcac_pkg::LANE_LAST) begin
          state_next = S_STATS;
        end
      end
      S_STATS: begin
        cmd.op = mcac_pkg::OP_STATS;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transaction");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state != S_IDLE)
    else $error("accepted transaction not started");

  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVM_GO || state == S_DIVE_GO) |=> !status.div_done)
    else $error("divider reports done right after start");

endmodule

// ===== design/multichannel_audio_compressor.sv =====
// multichannel audio compressor: one frame of six samples in, one frame out
// pass-through copies the samples; compressing runs a sum of squares, two divisions and
// 6 lane scalings, and above a nonzero threshold also two normalize-and-square log2
// passes and 16 exp2 steps
// a new frame waits until the last result is loaded; divider and sequencer are shared
// reset: synchronous active-high rst restores register defaults and clears statistics

module multichannel_audio_compressor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mcac_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mcac_pkg::out_item_t   out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  mcac_pkg::cfg_t         cfg;
  mcac_pkg::dp_cmd_t      cmd;
  mcac_pkg::dp_status_t   status;

  mcac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mcac_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
